FILE: sv/ohlcv_time_bucket_aggregator_top_assert.svh
// assertion macros for the ohlcv time bucket aggregator
// included by ohlcv_time_bucket_aggregator_top.sv, no other dependencies
`ifndef OHLCV_TIME_BUCKET_AGGREGATOR_TOP_ASSERT_SVH
`define OHLCV_TIME_BUCKET_AGGREGATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define OTBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OTBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define OTBA_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define OTBA_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: sv/otba_pkg.sv
// types, widths and helpers for the ohlcv time bucket aggregator
// no dependencies
package otba_pkg;

   localparam int TimeW  = 40;
   localparam int PriceW = 32;
   localparam int VolW   = 32;
   localparam int AccW   = 48;
   localparam int CountW = 32;
   localparam int MinW   = 11;
   localparam int LenW   = 17;
   localparam int StepW  = $clog2(TimeW + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FOLD
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // bucket length in seconds, zero minutes acts as one
   function automatic logic [LenW-1:0] otba_len(input logic [MinW-1:0] minutes);
      logic [LenW-1:0] m0;
      m0 = (minutes == '0) ? LenW'(1) : LenW'(minutes);
      return (m0 << 6) - (m0 << 2);
   endfunction

endpackage

FILE: sv/otba_div.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on otba_pkg
module otba_div (
   input  logic                           clock,
   input  logic                           reset,
   input  otba_pkg::div_ctrl_type         ctrl,
   input  logic [otba_pkg::TimeW-1:0]     dividend,
   input  logic [otba_pkg::LenW-1:0]      divisor,
   output otba_pkg::div_stat_type         stat,
   output logic [otba_pkg::LenW-1:0]      remainder
);
   import otba_pkg::*;

   logic [StepW-1:0] step_ff, step_in;
   logic             done_ff, done_in;
   logic [TimeW-1:0] num_ff, num_in;
   logic [LenW-1:0]  den_ff, den_in;
   logic [LenW-1:0]  rem_ff, rem_in;
   logic [LenW:0]    trial;
   logic [LenW:0]    diff;
   logic             busy;

   assign busy  = (step_ff != '0);
   assign trial = {rem_ff, num_ff[TimeW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (busy) begin
         step_in = step_ff - StepW'(1);
         num_in  = {num_ff[TimeW-2:0], 1'b0};
         rem_in  = (trial >= {1'b0, den_ff}) ? diff[LenW-1:0] : trial[LenW-1:0];
         done_in = (step_ff == StepW'(1));
      end else if (ctrl.start) begin
         step_in = StepW'(TimeW);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/ohlcv_time_bucket_aggregator_top.sv
// ohlcv time bucket aggregator: groups trades into time buckets, emits finished bars
// depends on otba_pkg, otba_div and ohlcv_time_bucket_aggregator_top_assert.svh
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    trade time, price, volume, final flag
//   rsp       out         rsp_valid/rsp_ready    bucket start/end, ohlc, volume, number
//   csr       in          csr_wr_en              bucket length in minutes
//
// a trade that stays in its bucket goes from accept through check and fold back to ready
// a trade that starts a run or leaves its bucket also passes the divide state: the bucket start
// is realigned by a 40-step serial remainder unit, one timestamp bit per cycle
// a finished bar waits in the output register; the next bar stalls the block until it is free
// synchronous active-high reset returns the block to an unstarted run with 1-minute buckets
`include "ohlcv_time_bucket_aggregator_top_assert.svh"

module ohlcv_time_bucket_aggregator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [otba_pkg::MinW-1:0]     csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [otba_pkg::TimeW-1:0]    req_trade_time,
   input  logic [otba_pkg::PriceW-1:0]   req_trade_price,
   input  logic [otba_pkg::VolW-1:0]     req_trade_volume,
   input  logic                          req_final_trade,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [otba_pkg::TimeW-1:0]    rsp_bucket_start,
   output logic [otba_pkg::TimeW-1:0]    rsp_bucket_end,
   output logic [otba_pkg::PriceW-1:0]   rsp_open_price,
   output logic [otba_pkg::PriceW-1:0]   rsp_high_price,
   output logic [otba_pkg::PriceW-1:0]   rsp_low_price,
   output logic [otba_pkg::PriceW-1:0]   rsp_close_price,
   output logic [otba_pkg::AccW-1:0]     rsp_volume_total,
   output logic [otba_pkg::CountW-1:0]   rsp_bucket_number
);
   import otba_pkg::*;

   state_type state_ff, state_in;

   logic [MinW-1:0]   minutes_ff;
   logic [TimeW-1:0]  t_ff;
   logic [PriceW-1:0] price_ff;
   logic [VolW-1:0]   vol_ff;
   logic              final_ff;

   logic              run_ff;
   logic [TimeW-1:0]  cs_ff;
   logic [PriceW-1:0] first_ff, top_ff, bot_ff, last_ff;
   logic [AccW-1:0]   acc_ff;
   logic              has_ff;
   logic [CountW-1:0] cnt_ff;

   logic              rsp_valid_ff;
   logic [TimeW-1:0]  rsp_start_ff, rsp_end_ff;
   logic [PriceW-1:0] rsp_open_ff, rsp_high_ff, rsp_low_ff, rsp_close_ff;
   logic [AccW-1:0]   rsp_vol_ff;
   logic [CountW-1:0] rsp_num_ff;

   logic [LenW-1:0]   len;
   logic [TimeW:0]    cs_end;
   logic              past_end;
   logic              out_free;
   logic [TimeW-1:0]  gap;
   logic [TimeW-1:0]  dividend;
   logic [LenW-1:0]   remainder;
   logic [AccW:0]     vol_sum;

   div_ctrl_type div_ctrl;
   div_stat_type div_stat;

   logic start_run, close_bkt, emit, realign, fold;

   assign len      = otba_len(minutes_ff);
   assign cs_end   = {1'b0, cs_ff} + (TimeW+1)'(len);
   assign past_end = ({1'b0, t_ff} >= cs_end);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign gap      = t_ff - cs_ff;
   assign dividend = run_ff ? gap : t_ff;
   assign vol_sum  = {1'b0, acc_ff} + (AccW+1)'(vol_ff);

   otba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (dividend),
      .divisor   (len),
      .stat      (div_stat),
      .remainder (remainder)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!run_ff) state_in = ST_DIV;
            else if (past_end) begin
               if (!has_ff || out_free) state_in = ST_DIV;
            end else state_in = ST_FOLD;
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready      = 1'b0;
      start_run      = 1'b0;
      close_bkt      = 1'b0;
      realign        = 1'b0;
      fold           = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_CHECK: begin
            start_run = !run_ff;
            close_bkt = run_ff && past_end && (!has_ff || out_free);
         end
         ST_DIV:   realign = div_stat.done;
         ST_FOLD:  fold = 1'b1;
         default:  req_ready = 1'b0;
      endcase
      emit           = close_bkt && has_ff;
      div_ctrl.start = start_run || close_bkt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         minutes_ff   <= MinW'(1);
         run_ff       <= 1'b0;
         cs_ff        <= '0;
         first_ff     <= '0;
         top_ff       <= '0;
         bot_ff       <= '1;
         last_ff      <= '0;
         acc_ff       <= '0;
         has_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) minutes_ff <= csr_wr_data;

         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (start_run || close_bkt) begin
            first_ff <= '0;
            top_ff   <= '0;
            bot_ff   <= '1;
            last_ff  <= '0;
            acc_ff   <= '0;
            has_ff   <= 1'b0;
         end
         if (start_run) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end
         if (emit) cnt_ff <= cnt_ff + CountW'(1);
         if (realign) cs_ff <= t_ff - TimeW'(remainder);

         if (fold) begin
            if (final_ff) begin
               run_ff   <= 1'b0;
               cs_ff    <= '0;
               cnt_ff   <= '0;
               first_ff <= '0;
               top_ff   <= '0;
               bot_ff   <= '1;
               last_ff  <= '0;
               acc_ff   <= '0;
               has_ff   <= 1'b0;
            end else begin
               if (!has_ff) first_ff <= price_ff;
               if (price_ff > top_ff) top_ff <= price_ff;
               if (price_ff < bot_ff) bot_ff <= price_ff;
               last_ff <= price_ff;
               acc_ff  <= vol_sum[AccW] ? '1 : vol_sum[AccW-1:0];
               has_ff  <= 1'b1;
            end
         end
      end

      if (req_valid && req_ready) begin
         t_ff     <= req_trade_time;
         price_ff <= req_trade_price;
         vol_ff   <= req_trade_volume;
         final_ff <= req_final_trade;
      end

      if (emit) begin
         rsp_start_ff <= cs_ff;
         rsp_end_ff   <= cs_end[TimeW-1:0];
         rsp_open_ff  <= first_ff;
         rsp_high_ff  <= top_ff;
         rsp_low_ff   <= bot_ff;
         rsp_close_ff <= last_ff;
         rsp_vol_ff   <= acc_ff;
         rsp_num_ff   <= cnt_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bucket_start  = rsp_start_ff;
   assign rsp_bucket_end    = rsp_end_ff;
   assign rsp_open_price    = rsp_open_ff;
   assign rsp_high_price    = rsp_high_ff;
   assign rsp_low_price     = rsp_low_ff;
   assign rsp_close_price   = rsp_close_ff;
   assign rsp_volume_total  = rsp_vol_ff;
   assign rsp_bucket_number = rsp_num_ff;

   `OTBA_ASSERT_NXT(a_accept_to_check, clock, reset, req_valid && req_ready, state_ff == ST_CHECK, "accepted beat did not reach check")
   `OTBA_ASSERT_IMP(a_div_only_in_div, clock, reset, div_stat.busy, state_ff == ST_DIV, "remainder unit busy outside divide state")
   `OTBA_ASSERT_IMP(a_rsp_from_check, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_CHECK, "result beat loaded outside check")

endmodule
